### rtl/assert_macros.svh
// assertion helpers used by the checker file cle_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// clocked assertion that also holds during reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// shared command, status and sequencer codes of the cursor list engine
// ----------------------------------------------------------------------------
package cle_pkg;

  typedef enum logic [3:0] {
    CMD_PREPEND    = 4'd0,
    CMD_APPEND     = 4'd1,
    CMD_INS_BEFORE = 4'd2,
    CMD_INS_AFTER  = 4'd3,
    CMD_DEL_FRONT  = 4'd4,
    CMD_DEL_BACK   = 4'd5,
    CMD_DEL_CURSOR = 4'd6,
    CMD_MOVE_FRONT = 4'd7,
    CMD_MOVE_BACK  = 4'd8,
    CMD_MOVE_PREV  = 4'd9,
    CMD_MOVE_NEXT  = 4'd10,
    CMD_GET        = 4'd11,
    CMD_SET        = 4'd12,
    CMD_CLEAR      = 4'd13,
    CMD_READ_FRONT = 4'd14,
    CMD_READ_BACK  = 4'd15
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PRECOND   = 2'd1,
    ST_POOL_FULL = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_RD2  = 6'b000100,
    S_W1   = 6'b001000,
    S_W2   = 6'b010000,
    S_DONE = 6'b100000
  } seq_state_t;

endpackage

### rtl/cle_ram.sv
// ----------------------------------------------------------------------------
// cle_ram
// generic simple dual-port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/cursor_list_engine.sv
// sequence: an accepted request steps through S_RD, S_RD2, S_W1, S_W2 and S_DONE
//   (read, read, write-back, write-back, result load); one request in flight at a time
// request flow: no new request is taken until the last one leaves S_DONE, set by the
//   read and write-back steps on the single-write-port next/prev/value memories plus the
//   idle accept state; a result held by out_stall keeps the next request waiting
// reset: synchronous active-low; list empty, cursor undefined, free chain empty
// ----------------------------------------------------------------------------
// cursor_list_engine
// doubly linked list with one cursor over a fixed pool of nodes
// ----------------------------------------------------------------------------
module cursor_list_engine
  import cle_pkg::*;
#(
  parameter int NODES       = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [3:0]                          in_command,
  input  logic [VALUE_WIDTH-1:0]              in_element_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [VALUE_WIDTH-1:0]              out_read_value,
  output logic [$clog2(NODES+1)-1:0]          out_list_length,
  output logic signed [$clog2(NODES+1)-1:0]   out_cursor_position
);

  // pointer width holds a node index or the null code NODES
  localparam int PW = $clog2(NODES + 1);
  localparam int AW = $clog2(NODES);
  localparam logic [PW-1:0] NIL = PW'(NODES);

  seq_state_t state_r, state_nxt;

  cmd_t                     cmd_r;
  logic [VALUE_WIDTH-1:0]   val_r;
  status_t                  status_r;
  logic [PW-1:0]            addr_r;

  // list bookkeeping
  logic [PW-1:0]            head_r, tail_r, cur_r, fh_r, um_r, cnt_r;
  logic signed [PW-1:0]     ccnt_r;

  // captured neighbor pointers and value of the addressed node
  logic [PW-1:0]            a_next_r, a_prev_r;
  logic [VALUE_WIDTH-1:0]   a_val_r;
  // nodes touched by the second write-back cycle
  logic [PW-1:0]            n_r, p_r, q_r, link_r;
  logic [VALUE_WIDTH-1:0]   rd_r;

  // result register
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [VALUE_WIDTH-1:0]   out_val_r;
  logic [PW-1:0]            out_len_r;
  logic signed [PW-1:0]     out_pos_r;

  // memory ports
  logic                     nx_we, pv_we, vl_we;
  logic [AW-1:0]            nx_wa, pv_wa, vl_wa, nx_ra, pv_ra, vl_ra;
  logic [PW-1:0]            nx_wd, pv_wd, nx_rd, pv_rd;
  logic [VALUE_WIDTH-1:0]   vl_wd, vl_rd;

  logic    in_acc, has_cur, empty, pool_full;
  cmd_t    in_cmd;
  status_t acc_status;
  logic [PW-1:0] acc_addr;

  // per-command node choices during the first write-back cycle
  logic [PW-1:0] ins_n, ins_p, ins_q, del_n;
  logic          is_ins, is_del;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign in_cmd    = cmd_t'(in_command);
  assign has_cur   = (cur_r != NIL);
  assign empty     = (cnt_r == '0);
  assign pool_full = (fh_r == NIL) && (um_r == NIL);

  // precondition and pool checks on the incoming request
  always_comb begin
    acc_status = ST_OK;
    acc_addr   = cur_r;
    case (in_cmd)
      CMD_PREPEND, CMD_APPEND: begin
        if (pool_full) acc_status = ST_POOL_FULL;
      end
      CMD_INS_BEFORE, CMD_INS_AFTER: begin
        if (!has_cur)       acc_status = ST_PRECOND;
        else if (pool_full) acc_status = ST_POOL_FULL;
      end
      CMD_DEL_FRONT, CMD_READ_FRONT: begin
        if (empty) acc_status = ST_PRECOND;
        acc_addr = head_r;
      end
      CMD_DEL_BACK, CMD_READ_BACK: begin
        if (empty) acc_status = ST_PRECOND;
        acc_addr = tail_r;
      end
      CMD_DEL_CURSOR, CMD_GET, CMD_SET: begin
        if (!has_cur) acc_status = ST_PRECOND;
      end
      default: begin
      end
    endcase
  end

  assign is_ins = (cmd_r == CMD_PREPEND) || (cmd_r == CMD_APPEND) ||
                  (cmd_r == CMD_INS_BEFORE) || (cmd_r == CMD_INS_AFTER);
  assign is_del = (cmd_r == CMD_DEL_FRONT) || (cmd_r == CMD_DEL_BACK) ||
                  (cmd_r == CMD_DEL_CURSOR);

  // new node comes from the free chain first, else from the high-water mark
  assign ins_n = (fh_r != NIL) ? fh_r : um_r;

  always_comb begin
    ins_p = cur_r;
    ins_q = a_next_r;
    del_n = cur_r;
    case (cmd_r)
      CMD_PREPEND:    begin ins_p = NIL;      ins_q = head_r; end
      CMD_APPEND:     begin ins_p = tail_r;   ins_q = NIL;    end
      CMD_INS_BEFORE: begin ins_p = a_prev_r; ins_q = cur_r;  end
      CMD_DEL_FRONT:  del_n = head_r;
      CMD_DEL_BACK:   del_n = tail_r;
      default: begin
      end
    endcase
  end

  // memory access per sequencer step
  always_comb begin
    nx_we = 1'b0; nx_wa = cur_r[AW-1:0]; nx_wd = NIL;
    pv_we = 1'b0; pv_wa = cur_r[AW-1:0]; pv_wd = NIL;
    vl_we = 1'b0; vl_wa = cur_r[AW-1:0]; vl_wd = val_r;
    nx_ra = addr_r[AW-1:0];
    pv_ra = addr_r[AW-1:0];
    vl_ra = addr_r[AW-1:0];
    case (state_r)
      S_RD2: begin
        // fetch the link out of the free-chain head
        nx_ra = fh_r[AW-1:0];
      end
      S_W1: begin
        if (status_r == ST_OK) begin
          if (is_ins) begin
            vl_we = 1'b1; vl_wa = ins_n[AW-1:0];
            pv_we = 1'b1; pv_wa = ins_n[AW-1:0]; pv_wd = ins_p;
            nx_we = 1'b1; nx_wa = ins_n[AW-1:0]; nx_wd = ins_q;
          end else if (is_del) begin
            // unlink the node from its neighbors
            nx_we = (a_prev_r != NIL); nx_wa = a_prev_r[AW-1:0]; nx_wd = a_next_r;
            pv_we = (a_next_r != NIL); pv_wa = a_next_r[AW-1:0]; pv_wd = a_prev_r;
          end else if (cmd_r == CMD_SET) begin
            vl_we = 1'b1;
          end else if (cmd_r == CMD_CLEAR && !empty) begin
            // splice the whole list ahead of the free chain
            nx_we = 1'b1; nx_wa = tail_r[AW-1:0]; nx_wd = fh_r;
          end
        end
      end
      S_W2: begin
        if (status_r == ST_OK) begin
          if (is_ins) begin
            nx_we = (p_r != NIL); nx_wa = p_r[AW-1:0]; nx_wd = n_r;
            pv_we = (q_r != NIL); pv_wa = q_r[AW-1:0]; pv_wd = n_r;
          end else if (is_del) begin
            // push the freed node on the free chain
            nx_we = 1'b1; nx_wa = n_r[AW-1:0]; nx_wd = link_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RD;
      S_RD:   state_nxt = S_RD2;
      S_RD2:  state_nxt = S_W1;
      S_W1:   state_nxt = S_W2;
      S_W2:   state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      cur_r       <= NIL;
      fh_r        <= NIL;
      um_r        <= '0;
      cnt_r       <= '0;
      ccnt_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result slot: load a finished request, else drop a taken one
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r    <= in_cmd;
            val_r    <= in_element_value;
            status_r <= acc_status;
            addr_r   <= acc_addr;
            rd_r     <= '0;
          end
        end
        S_RD2: begin
          a_next_r <= nx_rd;
          a_prev_r <= pv_rd;
          a_val_r  <= vl_rd;
        end
        S_W1: begin
          if (status_r == ST_OK) begin
            if (is_ins) begin
              // nx_rd holds the link out of the free-chain head here
              if (fh_r != NIL) fh_r <= nx_rd;
              else             um_r <= um_r + PW'(1);
              if (ins_p == NIL) head_r <= ins_n;
              if (ins_q == NIL) tail_r <= ins_n;
              if ((cmd_r == CMD_PREPEND || cmd_r == CMD_INS_BEFORE) && has_cur) begin
                ccnt_r <= ccnt_r + PW'(1);
              end
              cnt_r <= cnt_r + PW'(1);
              n_r   <= ins_n;
              p_r   <= ins_p;
              q_r   <= ins_q;
            end else if (is_del) begin
              if (del_n == cur_r) begin
                cur_r  <= NIL;
                ccnt_r <= '1;
              end else if (del_n == head_r && has_cur) begin
                ccnt_r <= ccnt_r - PW'(1);
              end
              if (a_prev_r == NIL) head_r <= a_next_r;
              if (a_next_r == NIL) tail_r <= a_prev_r;
              link_r <= fh_r;
              fh_r   <= del_n;
              n_r    <= del_n;
              cnt_r  <= cnt_r - PW'(1);
            end else begin
              case (cmd_r)
                CMD_MOVE_FRONT: begin
                  if (!empty) begin
                    cur_r  <= head_r;
                    ccnt_r <= '0;
                  end
                end
                CMD_MOVE_BACK: begin
                  if (!empty) begin
                    cur_r  <= tail_r;
                    ccnt_r <= cnt_r - PW'(1);
                  end
                end
                CMD_MOVE_PREV: begin
                  if (has_cur) begin
                    if (cur_r == head_r) begin
                      cur_r  <= NIL;
                      ccnt_r <= '1;
                    end else begin
                      cur_r  <= a_prev_r;
                      ccnt_r <= ccnt_r - PW'(1);
                    end
                  end
                end
                CMD_MOVE_NEXT: begin
                  if (has_cur) begin
                    if (cur_r == tail_r) begin
                      cur_r  <= NIL;
                      ccnt_r <= '1;
                    end else begin
                      cur_r  <= a_next_r;
                      ccnt_r <= ccnt_r + PW'(1);
                    end
                  end
                end
                CMD_GET, CMD_READ_FRONT, CMD_READ_BACK: rd_r <= a_val_r;
                CMD_CLEAR: begin
                  if (!empty) begin
                    fh_r   <= head_r;
                    head_r <= NIL;
                    tail_r <= NIL;
                    cnt_r  <= '0;
                    cur_r  <= NIL;
                    ccnt_r <= '1;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_status_r <= status_r;
            out_val_r    <= rd_r;
            out_len_r    <= cnt_r;
            out_pos_r    <= ccnt_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // node storage: value words, forward links, backward links
  cle_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(NODES)) u_value_mem (
    .clk(clk), .we(vl_we), .waddr(vl_wa), .wdata(vl_wd), .raddr(vl_ra), .rdata(vl_rd)
  );

  cle_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next_mem (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
  );

  cle_ram #(.WIDTH(PW), .DEPTH(NODES)) u_prev_mem (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd)
  );

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_read_value      = out_val_r;
  assign out_list_length     = out_len_r;
  assign out_cursor_position = out_pos_r;

endmodule

### rtl/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_checker
// port-level checks on the result channel of the cursor list engine
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cle_checker
  import cle_pkg::*;
#(
  parameter int NODES       = 256,
  parameter int VALUE_WIDTH = 32
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          out_status,
  input logic [VALUE_WIDTH-1:0]              out_read_value,
  input logic [$clog2(NODES+1)-1:0]          out_list_length,
  input logic signed [$clog2(NODES+1)-1:0]   out_cursor_position
);

  localparam int PW = $clog2(NODES + 1);

  // a stalled result stays offered
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)
  // failed requests return no data
  `CHK_ASSERT(a_err_zero, clk, rst_n, out_valid && out_status != ST_OK |-> out_read_value == '0)
  // a defined cursor lies inside the list
  `CHK_ASSERT(a_cur_in_list, clk, rst_n, out_valid && !out_cursor_position[PW-1] |-> out_cursor_position < out_list_length)
  // the pool is only full when every node is in the list
  `CHK_ASSERT(a_full_len, clk, rst_n, out_valid && out_status == ST_POOL_FULL |-> out_list_length == PW'(NODES))

endmodule

bind cursor_list_engine cle_checker #(.NODES(NODES), .VALUE_WIDTH(VALUE_WIDTH)) u_cle_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_status(out_status), .out_read_value(out_read_value),
  .out_list_length(out_list_length), .out_cursor_position(out_cursor_position)
);

### dv/list_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_scoreboard
// mirrors the linked list and its cursor, queues and checks command results
// ----------------------------------------------------------------------------
class list_scoreboard;
  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       read_value;
    logic [8:0]        list_length;
    logic signed [8:0] cursor_position;
  } list_result_t;

  localparam int POOL = 256;
  localparam int NIL  = 256;

  logic [31:0] node_val[POOL];
  int node_nxt[POOL];
  int node_prv[POOL];
  int head, tail, cur, free_head, unused_mark, count, cur_idx;
  list_result_t pending_results[$];
  int errors;
  int checked;

  function new();
    head = NIL; tail = NIL; cur = NIL; free_head = NIL;
    unused_mark = 0; count = 0; cur_idx = -1; errors = 0; checked = 0;
  endfunction

  function int take_node();
    int n;
    if (free_head < NIL) begin
      n = free_head;
      free_head = node_nxt[n];
      return n;
    end
    if (unused_mark < POOL) begin
      unused_mark++;
      return unused_mark - 1;
    end
    return NIL;
  endfunction

  function void note_command(cle_pkg::cmd_t cmd, logic [31:0] val);
    list_result_t r;
    bit has_cur;
    int n, p, q;
    has_cur = cur < NIL;
    r.status = cle_pkg::ST_OK;
    r.read_value = '0;
    case (cmd)
      cle_pkg::CMD_PREPEND, cle_pkg::CMD_APPEND,
      cle_pkg::CMD_INS_BEFORE, cle_pkg::CMD_INS_AFTER: begin
        if ((cmd == cle_pkg::CMD_INS_BEFORE || cmd == cle_pkg::CMD_INS_AFTER) && !has_cur)
          r.status = cle_pkg::ST_PRECOND;
        else begin
          n = take_node();
          if (n >= NIL) r.status = cle_pkg::ST_POOL_FULL;
          else begin
            node_val[n] = val;
            case (cmd)
              cle_pkg::CMD_PREPEND:    begin p = NIL; q = head; end
              cle_pkg::CMD_APPEND:     begin p = tail; q = NIL; end
              cle_pkg::CMD_INS_BEFORE: begin p = node_prv[cur]; q = cur; end
              default:                 begin p = cur; q = node_nxt[cur]; end
            endcase
            node_prv[n] = p;
            node_nxt[n] = q;
            if (p < NIL) node_nxt[p] = n; else head = n;
            if (q < NIL) node_prv[q] = n; else tail = n;
            if ((cmd == cle_pkg::CMD_PREPEND || cmd == cle_pkg::CMD_INS_BEFORE) && has_cur)
              cur_idx++;
            count++;
          end
        end
      end
      cle_pkg::CMD_DEL_FRONT, cle_pkg::CMD_DEL_BACK, cle_pkg::CMD_DEL_CURSOR: begin
        if ((cmd == cle_pkg::CMD_DEL_CURSOR && !has_cur) || count == 0)
          r.status = cle_pkg::ST_PRECOND;
        else begin
          n = (cmd == cle_pkg::CMD_DEL_FRONT) ? head :
              (cmd == cle_pkg::CMD_DEL_BACK) ? tail : cur;
          if (n == cur) begin cur = NIL; cur_idx = -1; end
          else if (n == head && has_cur) cur_idx--;
          p = node_prv[n];
          q = node_nxt[n];
          if (p < NIL) node_nxt[p] = q; else head = q;
          if (q < NIL) node_prv[q] = p; else tail = p;
          node_nxt[n] = free_head;
          free_head = n;
          count--;
        end
      end
      cle_pkg::CMD_MOVE_FRONT: if (count != 0) begin cur = head; cur_idx = 0; end
      cle_pkg::CMD_MOVE_BACK:  if (count != 0) begin cur = tail; cur_idx = count - 1; end
      cle_pkg::CMD_MOVE_PREV: if (has_cur) begin
        if (cur == head) begin cur = NIL; cur_idx = -1; end
        else begin cur = node_prv[cur]; cur_idx--; end
      end
      cle_pkg::CMD_MOVE_NEXT: if (has_cur) begin
        if (cur == tail) begin cur = NIL; cur_idx = -1; end
        else begin cur = node_nxt[cur]; cur_idx++; end
      end
      cle_pkg::CMD_GET, cle_pkg::CMD_SET: begin
        if (!has_cur) r.status = cle_pkg::ST_PRECOND;
        else if (cmd == cle_pkg::CMD_GET) r.read_value = node_val[cur];
        else node_val[cur] = val;
      end
      cle_pkg::CMD_CLEAR: if (count != 0) begin
        node_nxt[tail] = free_head;
        free_head = head;
        head = NIL; tail = NIL; count = 0; cur = NIL; cur_idx = -1;
      end
      default: begin
        if (count == 0) r.status = cle_pkg::ST_PRECOND;
        else r.read_value = node_val[cmd == cle_pkg::CMD_READ_FRONT ? head : tail];
      end
    endcase
    r.list_length = count[8:0];
    r.cursor_position = cur_idx[8:0];
    pending_results.push_back(r);
  endfunction

  function void check_result(list_result_t got);
    list_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    checked++;
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      errors++;
    end
    if (got.read_value !== want.read_value) begin
      $display("%0t: read_value expected %h actual %h", $time, want.read_value,
               got.read_value);
      errors++;
    end
    if (got.list_length !== want.list_length) begin
      $display("%0t: list_length expected %0d actual %0d", $time, want.list_length,
               got.list_length);
      errors++;
    end
    if (got.cursor_position !== want.cursor_position) begin
      $display("%0t: cursor_position expected %0d actual %0d", $time,
               want.cursor_position, got.cursor_position);
      errors++;
    end
  endfunction
endclass

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives random and directed list commands into the cursor list engine and
// compares every result against a behavioral list with a cursor
// ----------------------------------------------------------------------------
module tb;
  import cle_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_command;
  logic [31:0] in_element_value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [31:0] out_read_value;
  logic [8:0]  out_list_length;
  logic signed [8:0] out_cursor_position;

  list_scoreboard board;
  int cycles;
  int long_hold;   // receiver hold-off cycles still to go
  bit pool_filled;

  cursor_list_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_element_value(in_element_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_read_value(out_read_value),
    .out_list_length(out_list_length), .out_cursor_position(out_cursor_position)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // cycle limit: request sequencing, stalls and gaps, many times over
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall pattern while cycles[12] is set, long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (($urandom % 8) < (cycles[12] ? 3 : 0));
    end
  end

  // result monitor, sampled at the edge where the result is taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_status, out_read_value, out_list_length,
                          out_cursor_position});
  end

  // one request; held until accepted
  task automatic send_request(cmd_t cmd, logic [31:0] val);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_element_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(cmd, val);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // random command, weighted toward inserts and cursor traffic
  function automatic cmd_t pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (pool_filled && r < 40) return cmd_t'($urandom_range(4, 6));
    if (r < 30) return cmd_t'($urandom_range(0, 3));
    if (r < 45) return cmd_t'($urandom_range(4, 6));
    if (r < 75) return cmd_t'($urandom_range(7, 10));
    if (r < 97) return cmd_t'($urandom_range(11, 15));
    return CMD_CLEAR;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int burst;
    board = new();
    cycles = 0;
    long_hold = 0;
    pool_filled = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_PREPEND;
    in_element_value = '0;
    out_stall = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: precondition errors on an empty list, undefined cursor moves
    send_request(CMD_DEL_FRONT, 0);
    send_request(CMD_DEL_BACK, 0);
    send_request(CMD_DEL_CURSOR, 0);
    send_request(CMD_READ_FRONT, 0);
    send_request(CMD_READ_BACK, 0);
    send_request(CMD_GET, 0);
    send_request(CMD_SET, 32'h1234);
    send_request(CMD_INS_BEFORE, 1);
    send_request(CMD_INS_AFTER, 2);
    send_request(CMD_MOVE_FRONT, 0);
    send_request(CMD_MOVE_NEXT, 0);
    send_request(CMD_CLEAR, 0);
    // directed: build, walk past both ends, delete under the cursor
    send_request(CMD_APPEND, 32'hffff_ffff);
    send_request(CMD_PREPEND, 32'h0);
    send_request(CMD_MOVE_BACK, 0);
    send_request(CMD_INS_BEFORE, 32'ha5a5_a5a5);
    send_request(CMD_INS_AFTER, 32'h5a5a_5a5a);
    send_request(CMD_DEL_FRONT, 0);
    send_request(CMD_GET, 0);
    send_request(CMD_SET, 32'hdead_beef);
    send_request(CMD_MOVE_NEXT, 0);
    send_request(CMD_MOVE_NEXT, 0);
    send_request(CMD_MOVE_FRONT, 0);
    send_request(CMD_MOVE_PREV, 0);
    send_request(CMD_DEL_CURSOR, 0);
    drain_results();

    // fill the pool to overflow while the receiver holds off
    long_hold = 300;
    for (int i = 0; i < 262; i++) send_request(CMD_APPEND, $urandom);
    drain_results();
    send_request(CMD_MOVE_FRONT, 0);
    send_request(CMD_PREPEND, 1);
    send_request(CMD_DEL_BACK, 0);
    send_request(CMD_INS_AFTER, 2);
    pool_filled = 1;
    // keep high fill for a while, then clear and reuse the free chain
    for (int i = 0; i < 120; i++) send_request(pick_command(), pick_value());
    pool_filled = 0;
    send_request(CMD_CLEAR, 0);
    drain_results();

    // random bursts with gaps
    for (int i = 0; i < 400; i += burst) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) send_request(pick_command(), pick_value());
      if ($urandom_range(0, 1)) idle_gap($urandom_range(1, 12));
    end
    drain_results();

    $display("ran %0d checked results: empty-list and cursor errors, pool overflow,",
             board.checked);
    $display("free chain reuse, cursor walks and random command bursts");
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
